// ----- design/sfq_pkg.sv -----
// Shared types and codes for the searchable FIFO queue.
package sfq_pkg;

	// Request codes.
	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_MOD  = 2'd2;
	localparam logic [1:0] REQ_FIND = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Returned by a dequeue on an empty queue.
	localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

	typedef logic signed [31:0] word_t;

	// Per-cell control from the queue controller.
	typedef struct packed {
		logic occupied;  // cell holds a queued word
		logic shift;     // take the neighbor's word (dequeue)
		logic load;      // take the enqueued word
		logic modify;    // replace the word on a match
		logic capture;   // register the match flag (find)
	} cell_ctrl_t;

endpackage

// ----- design/sfq_cell.sv -----
// One storage cell of the queue: a word, its comparator and its match flag.
module sfq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sfq_pkg::cell_ctrl_t ctrl,
	input  sfq_pkg::word_t     neighbor_word,
	input  sfq_pkg::word_t     value,
	input  sfq_pkg::word_t     new_value,
	output sfq_pkg::word_t     word,
	output logic               hit
);
	import sfq_pkg::*;

	word_t data_q;
	logic  hit_q;
	logic  match;

	// A match counts only for an occupied cell.
	assign match = ctrl.occupied && (data_q == value);

	// Stored word: shift toward the head, load at the tail, or replace.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= neighbor_word;
		end else if (ctrl.load) begin
			data_q <= value;
		end else if (ctrl.modify && match) begin
			data_q <= new_value;
		end
	end

	// Match flag for a find request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.capture) begin
			hit_q <= match;
		end
	end

	assign word = data_q;
	assign hit  = hit_q;

endmodule

// ----- design/searchable_fifo_queue.sv -----
// Top level of the searchable FIFO queue: controller and row of cells.
//
//  Channel   Signals                               Direction
//  request   start, busy, req_type, value,         in (busy out)
//            new_value
//  result    done, out_value, found, status        out
//
// For enqueue, dequeue and modify the result strobe follows the accepted
// request at the next edge, and busy stays low.
// For a find every cell registers its match flag, then the flags are ORed
// into the result; busy is high while the flags are being ORed.
// The oldest word always sits in cell 0; a dequeue shifts the row one cell.
// Reset empties the queue; the cell words are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module searchable_fifo_queue #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [1:0]     req_type,
	input  sfq_pkg::word_t value,
	input  sfq_pkg::word_t new_value,
	output logic           done,
	output sfq_pkg::word_t out_value,
	output logic           found,
	output logic [1:0]     status
);
	import sfq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [CW-1:0] count_q;
	logic          find_s1;
	logic          done_q;
	word_t         out_value_q;
	logic          found_q;
	logic [1:0]    status_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          do_enq;
	logic          do_deq;
	word_t         words [DEPTH];
	logic [DEPTH-1:0] hits;

	assign accept   = start && !busy;
	assign is_full  = (count_q == FULL_COUNT);
	assign is_empty = (count_q == '0);
	assign do_enq   = accept && (req_type == REQ_ENQ) && !is_full;
	assign do_deq   = accept && (req_type == REQ_DEQ) && !is_empty;
	assign busy     = find_s1;

	// Row of cells; each but the last takes its neighbor's word on a dequeue.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		cell_ctrl_t ctrl;
		word_t      nb;

		assign ctrl.occupied = (IDX < count_q);
		assign ctrl.shift    = do_deq;
		assign ctrl.load     = do_enq && (IDX == count_q);
		assign ctrl.modify   = accept && (req_type == REQ_MOD);
		assign ctrl.capture  = accept && (req_type == REQ_FIND);

		if (i == DEPTH - 1) begin : g_last
			assign nb = words[i];
		end else begin : g_mid
			assign nb = words[i + 1];
		end

		sfq_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.neighbor_word(nb),
			.value        (value),
			.new_value    (new_value),
			.word         (words[i]),
			.hit          (hits[i])
		);
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_enq) begin
			count_q <= count_q + CW'(1);
		end else if (do_deq) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result control: strobe and the pending find.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			find_s1 <= accept && (req_type == REQ_FIND);
			done_q  <= (accept && (req_type != REQ_FIND)) || find_s1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (find_s1) begin
			out_value_q <= '0;
			found_q     <= |hits;
			status_q    <= ST_OK;
		end else if (accept) begin
			found_q <= 1'b0;
			case (req_type)
				REQ_ENQ: begin
					out_value_q <= '0;
					status_q    <= is_full ? ST_FULL : ST_OK;
				end
				REQ_DEQ: begin
					if (is_empty) begin
						out_value_q <= EMPTY_WORD;
						status_q    <= ST_EMPTY;
					end else begin
						out_value_q <= words[0];
						status_q    <= ST_OK;
					end
				end
				default: begin
					out_value_q <= '0;
					status_q    <= ST_OK;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign out_value = out_value_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

// ----- dv/searchable_fifo_queue_check.sv -----
// Checker for the searchable FIFO queue: predicts every result and compares it.
module searchable_fifo_queue_check #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  logic [1:0]     req_type,
	input  sfq_pkg::word_t value,
	input  sfq_pkg::word_t new_value,
	input  logic           done,
	input  sfq_pkg::word_t out_value,
	input  logic           found,
	input  logic [1:0]     status,
	output int             fail_count,
	output int             pending
);
	import sfq_pkg::*;

	typedef struct packed {
		word_t      out_value;
		logic       found;
		logic [1:0] status;
	} queue_reply_t;

	// Circular-buffer copy of the queue contents.
	word_t slot_mem [DEPTH];
	int    head_ptr;
	int    tail_ptr;
	int    fill;

	queue_reply_t expected_replies[$];
	int           errors;

	// Applies one request to the queue copy and returns the reply it should give.
	task automatic apply_request(input logic [1:0] kind, input word_t v, input word_t nv,
			output queue_reply_t r);
		int idx;
		r = '{out_value: '0, found: 1'b0, status: ST_OK};
		case (kind)
			REQ_ENQ: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot_mem[tail_ptr] = v;
					tail_ptr = (tail_ptr + 1) % DEPTH;
					fill++;
				end
			end
			REQ_DEQ: begin
				if (fill == 0) begin
					r.out_value = EMPTY_WORD;
					r.status = ST_EMPTY;
				end else begin
					r.out_value = slot_mem[head_ptr];
					head_ptr = (head_ptr + 1) % DEPTH;
					fill--;
				end
			end
			default: begin
				// Modify and find look at occupied slots only.
				idx = head_ptr;
				for (int k = 0; k < fill; k++) begin
					if (slot_mem[idx] == v) begin
						if (kind == REQ_MOD)
							slot_mem[idx] = nv;
						else
							r.found = 1'b1;
					end
					idx = (idx + 1) % DEPTH;
				end
			end
		endcase
	endtask

	// Reports a failure; only the first few get a line of their own.
	task automatic note_failure(input string what, input queue_reply_t exp_r,
			input queue_reply_t got_r);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s,", what,
				" expected value %0d found %0b status %0d,",
				exp_r.out_value, exp_r.found, exp_r.status,
				" got value %0d found %0b status %0d",
				got_r.out_value, got_r.found, got_r.status);
	endtask

	// Results are compared before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		queue_reply_t exp_r;
		queue_reply_t got_r;
		if (!arst_n) begin
			head_ptr = 0;
			tail_ptr = 0;
			fill = 0;
			errors = 0;
			expected_replies.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				got_r = '{out_value: out_value, found: found, status: status};
				if (expected_replies.size() == 0) begin
					note_failure("result with no request waiting", '0, got_r);
				end else begin
					exp_r = expected_replies.pop_front();
					if (got_r.out_value !== exp_r.out_value || got_r.found !== exp_r.found
							|| got_r.status !== exp_r.status)
						note_failure("wrong result", exp_r, got_r);
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				apply_request(req_type, value, new_value, exp_r);
				expected_replies.push_back(exp_r);
			end
			fail_count <= errors;
			pending <= expected_replies.size();
		end
	end

endmodule

// ----- dv/searchable_fifo_queue_test.sv -----
// Top of the searchable FIFO queue testbench: clock, reset, requests and verdict.
module searchable_fifo_queue_test;
	import sfq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1530;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} traffic_mix_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] req_type;
	word_t      value;
	word_t      new_value;
	logic       done;
	word_t      out_value;
	logic       found;
	logic [1:0] status;
	int         fail_count;
	int         pending;
	int         cycle_count;

	// Words that requests draw from, so that finds and modifies hit often.
	word_t hot_words [8];

	searchable_fifo_queue #(.DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.value    (value),
		.new_value(new_value),
		.done     (done),
		.out_value(out_value),
		.found    (found),
		.status   (status)
	);

	searchable_fifo_queue_check #(.DEPTH(DEPTH)) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value     (value),
		.new_value (new_value),
		.done      (done),
		.out_value (out_value),
		.found     (found),
		.status    (status),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it.
	task automatic issue_request(input logic [1:0] kind, input word_t v, input word_t nv);
		start <= 1'b1;
		req_type <= kind;
		value <= v;
		new_value <= nv;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Idle time between requests: mostly short, now and then long.
	task automatic idle_gap();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (r < 40)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(11, 30);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic word_t pick_word();
		if ($urandom_range(0, 9) < 5)
			return hot_words[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_kind(input traffic_mix_t mix);
		int r;
		int enq_pct;
		int deq_pct;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				enq_pct = 60;
				deq_pct = 15;
			end
			MIX_DRAIN: begin
				enq_pct = 15;
				deq_pct = 60;
			end
			default: begin
				enq_pct = 30;
				deq_pct = 30;
			end
		endcase
		if (r < enq_pct)
			return REQ_ENQ;
		if (r < enq_pct + deq_pct)
			return REQ_DEQ;
		if (r < enq_pct + deq_pct + (100 - enq_pct - deq_pct) / 2)
			return REQ_MOD;
		return REQ_FIND;
	endfunction

	initial begin
		traffic_mix_t mix;
		int           sent;
		int           phase_len;
		logic         no_idle;
		logic [1:0]   kind;

		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ENQ;
		value = '0;
		new_value = '0;
		cycle_count = 0;
		hot_words[0] = -32'sd1;
		hot_words[1] = 32'sd0;
		hot_words[2] = 32'sh8000_0000;
		hot_words[3] = 32'sh7FFF_FFFF;
		hot_words[4] = 32'sd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, extreme words, stored -1, modify and find.
		issue_request(REQ_DEQ, 32'sd0, 32'sd0);
		issue_request(REQ_FIND, 32'sd0, 32'sd0);
		issue_request(REQ_MOD, 32'sd0, 32'sd5);
		issue_request(REQ_ENQ, -32'sd1, 32'sd0);
		issue_request(REQ_ENQ, 32'sh8000_0000, 32'sd0);
		issue_request(REQ_ENQ, 32'sh7FFF_FFFF, 32'sd0);
		issue_request(REQ_ENQ, 32'sd0, 32'sd0);
		issue_request(REQ_FIND, -32'sd1, 32'sd0);
		issue_request(REQ_FIND, 32'sd5, 32'sd0);
		issue_request(REQ_MOD, 32'sh8000_0000, 32'sh7FFF_FFFF);
		idle_gap();
		issue_request(REQ_FIND, 32'sh8000_0000, 32'sd0);
		issue_request(REQ_MOD, 32'sh7FFF_FFFF, -32'sd1);
		issue_request(REQ_DEQ, 32'sd0, 32'sd0);
		issue_request(REQ_DEQ, 32'sd0, 32'sd0);
		idle_gap();
		issue_request(REQ_DEQ, 32'sd0, 32'sd0);
		issue_request(REQ_FIND, 32'sd0, 32'sd0);
		issue_request(REQ_DEQ, 32'sd0, 32'sd0);
		issue_request(REQ_DEQ, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
		issue_request(REQ_FIND, 32'sd0, 32'sd0);

		// Random phases that alternate between filling, draining and mixed traffic.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == 0) begin
				mix = MIX_FILL;
				phase_len = 80;
			end else begin
				mix = traffic_mix_t'($urandom_range(0, 2));
				phase_len = $urandom_range(30, 120);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 5; i < 8; i++)
				hot_words[i] = $urandom;
			for (int i = 0; i < phase_len; i++) begin
				kind = pick_kind(mix);
				issue_request(kind, pick_word(), pick_word());
				sent++;
				if (!no_idle)
					idle_gap();
			end
		end
		start <= 1'b0;

		// Drain the outstanding results, then allow a few quiet cycles.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sfq_pkg.sv
design/sfq_cell.sv
design/searchable_fifo_queue.sv
dv/searchable_fifo_queue_check.sv
dv/searchable_fifo_queue_test.sv
